[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion helpers, clocked on clk_i and reset by rst_ni
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every edge outside reset
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

[rtl/rspu_pkg.sv]
// ----------------------------------------------------------------------------
// rspu_pkg
// constants, types and helpers of the rectangle sum point update block
// ----------------------------------------------------------------------------
package rspu_pkg;

  localparam int GRID  = 64;
  localparam int CW    = 7;                   // coordinate and extent width
  localparam int SW    = CW + 1;              // walk index width, holds overshoot
  localparam int IW    = $clog2(GRID);
  localparam int DEPTH = GRID * GRID;
  localparam int AW    = $clog2(DEPTH);
  localparam int SUM_W = 48;
  localparam int VAL_W = 16;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_ROW   = 6'b000100,
    ST_CELL  = 6'b001000,
    ST_WB    = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  typedef struct packed {
    logic load;        // take the input beat
    logic row_init;    // restart column walk
    logic i_step;      // next row of the walk
    logic corner_next; // next prefix corner of a query
    logic wb;          // use read data of current cell
    logic clr_wr;      // write zero during clearing pass
    logic out_load;    // move the sum into the output register
  } cmd_t;

  typedef struct packed {
    logic skip;        // input beat needs no tree walk
    logic in_query;    // input beat is a query
    logic op_query;    // item at work is a query
    logic i_live;      // row index inside the tree
    logic j_live;      // column index inside the tree
    logic corner_last; // fourth prefix of a query
    logic clr_last;    // last entry of the clearing pass
    logic out_free;    // output register can take a sum
  } sts_t;

  function automatic logic [SW-1:0] low_bit(input logic [SW-1:0] v);
    return v & (~v + SW'(1));
  endfunction

endpackage

[rtl/rspu_ram.sv]
// ----------------------------------------------------------------------------
// rspu_ram
// single port ram, one access per cycle, registered read data
// ----------------------------------------------------------------------------
module rspu_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/rspu_dp.sv]
// ----------------------------------------------------------------------------
// rspu_dp
// datapath: extent register, item registers, fenwick walk indexes,
// accumulator, cell memory and output register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rspu_dp import rspu_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CW-1:0]           cfg_grid_extent_i,
  input  logic                    opcode_i,
  input  logic [CW-1:0]           x_first_i,
  input  logic [CW-1:0]           y_first_i,
  input  logic [CW-1:0]           x_last_i,
  input  logic [CW-1:0]           y_last_i,
  input  logic signed [VAL_W-1:0] value_i,
  input  logic                    out_stall_i,
  output logic                    out_valid_o,
  output logic signed [SUM_W-1:0] rect_sum_o,
  input  cmd_t                    cmd_i,
  output sts_t                    sts_o
);

  logic [CW-1:0]    ext_q;
  logic [CW-1:0]    eff_ext;
  logic             op_q;
  logic [CW-1:0]    x1_q, y1_q, x2_q, y2_q;
  logic [CW-1:0]    qx1, qy1, qx2, qy2;
  logic [SUM_W-1:0] delta_q;
  logic [1:0]       corner_q;
  logic [SW-1:0]    i_q, j_q;
  logic [SW-1:0]    i_next, j_next;
  logic [SUM_W-1:0] acc_q;
  logic [AW-1:0]    clr_cnt_q;
  logic             out_valid_q;
  logic [SUM_W-1:0] rect_sum_q;
  logic             add_ok, q_empty;
  logic [IW-1:0]    i_m1, j_m1;
  logic [AW-1:0]    cell_addr, ram_addr;
  logic             ram_we;
  logic [SUM_W-1:0] ram_wdata, ram_rdata;

  function automatic logic [SW-1:0] start_x(input logic [1:0] c, input logic op,
                                            input logic [CW-1:0] x1,
                                            input logic [CW-1:0] x2);
    if (!op) return SW'(x1);
    return c[0] ? SW'(x1) - SW'(1) : SW'(x2);
  endfunction

  function automatic logic [SW-1:0] start_y(input logic [1:0] c, input logic op,
                                            input logic [CW-1:0] y1,
                                            input logic [CW-1:0] y2);
    if (!op) return SW'(y1);
    return c[1] ? SW'(y1) - SW'(1) : SW'(y2);
  endfunction

  // clamp the extent and the query bounds
  assign eff_ext = (ext_q > CW'(GRID)) ? CW'(GRID) : ext_q;
  assign qx1     = (x_first_i == '0) ? CW'(1) : x_first_i;
  assign qy1     = (y_first_i == '0) ? CW'(1) : y_first_i;
  assign qx2     = (x_last_i > eff_ext) ? eff_ext : x_last_i;
  assign qy2     = (y_last_i > eff_ext) ? eff_ext : y_last_i;
  assign add_ok  = (x_first_i != '0) && (x_first_i <= eff_ext) &&
                   (y_first_i != '0) && (y_first_i <= eff_ext);
  assign q_empty = (eff_ext == '0) || (qx1 > qx2) || (qy1 > qy2);

  // updates walk upward, prefix reads walk downward
  assign i_next = op_q ? (i_q - low_bit(i_q)) : (i_q + low_bit(i_q));
  assign j_next = op_q ? (j_q - low_bit(j_q)) : (j_q + low_bit(j_q));

  assign i_m1      = IW'(i_q - SW'(1));
  assign j_m1      = IW'(j_q - SW'(1));
  assign cell_addr = AW'(i_m1) * AW'(GRID) + AW'(j_m1);
  assign ram_addr  = cmd_i.clr_wr ? clr_cnt_q : cell_addr;
  assign ram_we    = cmd_i.clr_wr | (cmd_i.wb & ~op_q);
  assign ram_wdata = cmd_i.clr_wr ? '0 : (ram_rdata + delta_q);

  rspu_ram #(
    .Width (SUM_W),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_q       <= CW'(64);
      op_q        <= 1'b0;
      corner_q    <= '0;
      i_q         <= '0;
      j_q         <= '0;
      acc_q       <= '0;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        ext_q <= cfg_grid_extent_i;
      end
      if (cmd_i.clr_wr) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
      end
      if (cmd_i.load) begin
        op_q     <= opcode_i;
        corner_q <= '0;
        acc_q    <= '0;
        i_q      <= opcode_i ? SW'(qx2) : SW'(x_first_i);
      end
      if (cmd_i.row_init) begin
        j_q <= start_y(corner_q, op_q, y1_q, y2_q);
      end
      if (cmd_i.i_step) begin
        i_q <= i_next;
      end
      if (cmd_i.corner_next) begin
        corner_q <= corner_q + 2'd1;
        i_q      <= start_x(corner_q + 2'd1, op_q, x1_q, x2_q);
      end
      if (cmd_i.wb) begin
        j_q <= j_next;
        if (op_q) begin
          acc_q <= (corner_q[0] ^ corner_q[1]) ? (acc_q - ram_rdata)
                                               : (acc_q + ram_rdata);
        end
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x1_q    <= opcode_i ? qx1 : x_first_i;
      y1_q    <= opcode_i ? qy1 : y_first_i;
      x2_q    <= qx2;
      y2_q    <= qy2;
      delta_q <= {{(SUM_W-VAL_W){value_i[VAL_W-1]}}, value_i};
    end
    if (cmd_i.out_load) begin
      rect_sum_q <= acc_q;
    end
  end

  always_comb begin
    sts_o             = '0;
    sts_o.skip        = opcode_i ? q_empty : ~add_ok;
    sts_o.in_query    = opcode_i;
    sts_o.op_query    = op_q;
    sts_o.i_live      = op_q ? (i_q != '0) : (i_q <= SW'(GRID));
    sts_o.j_live      = op_q ? (j_q != '0) : (j_q <= SW'(GRID));
    sts_o.corner_last = (corner_q == 2'd3);
    sts_o.clr_last    = (clr_cnt_q == AW'(DEPTH - 1));
    sts_o.out_free    = ~out_valid_q | ~out_stall_i;
  end

  assign out_valid_o = out_valid_q;
  assign rect_sum_o  = rect_sum_q;

  `ASSERT_NEVER(a_query_no_write, ram_we && !cmd_i.clr_wr && op_q, "query wrote cell memory")
  `ASSERT_PROP(a_query_row_range, op_q |-> i_q <= SW'(GRID), "query row off tree")
  `ASSERT_PROP(a_query_col_range, cmd_i.wb && op_q |-> j_q <= SW'(GRID), "query column off tree")
  `ASSERT_PROP(a_out_loaded, cmd_i.out_load |=> out_valid_q && (rect_sum_q == $past(acc_q)), "sum not presented")

endmodule

[rtl/rspu_ctrl.sv]
// ----------------------------------------------------------------------------
// rspu_ctrl
// controller: clearing pass, fenwick row and column walk, result hand-off
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rspu_ctrl import rspu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output cmd_t cmd_o,
  input  sts_t sts_i
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (!sts_i.skip) begin
            state_d = ST_ROW;
          end else if (sts_i.in_query) begin
            state_d = ST_DONE;
          end
        end
      end
      ST_ROW: begin
        if (sts_i.i_live) begin
          cmd_o.row_init = 1'b1;
          state_d        = ST_CELL;
        end else if (!sts_i.op_query) begin
          state_d = ST_IDLE;
        end else if (sts_i.corner_last) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.corner_next = 1'b1;
        end
      end
      ST_CELL: begin
        if (sts_i.j_live) begin
          state_d = ST_WB;
        end else begin
          cmd_o.i_step = 1'b1;
          state_d      = ST_ROW;
        end
      end
      ST_WB: begin
        cmd_o.wb = 1'b1;
        state_d  = ST_CELL;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  `ASSERT_PROP(a_out_when_free, cmd_o.out_load |-> sts_i.out_free, "sum dropped on busy output")
  `ASSERT_PROP(a_wb_after_cell, (state_q == ST_WB) |-> $past(state_q == ST_CELL), "write back without read")
  `ASSERT_PROP(a_clear_blocks, (state_q == ST_CLEAR) |-> (in_stall_o && !cmd_o.load), "item taken while clearing")

endmodule

[rtl/rectangle_sum_point_update.sv]
// ----------------------------------------------------------------------------
// rectangle_sum_point_update
// online 2d rectangle sums over a grid of signed weights with point adds,
// kept as a 2d fenwick tree in one single port memory
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+-------------------------------
//  in       | sink      | in_valid_i/in_stall_o  | opcode, x/y first, x/y last, value
//  out      | source    | out_valid_o/out_stall_i| rect_sum (queries only)
//  cfg      | sink      | cfg_we_i               | cfg_grid_extent_i
//
//  after reset a clearing pass writes zero to all 4096 cells
//  with in_stall_o high; cfg writes are taken during it
//  every fenwick cell costs a read and then an add or write back on the
//  one memory port; each row of the walk adds bookkeeping states
//  an add walks the tree upward, a query runs four prefix walks downward;
//  an ignored add needs no walk, an empty query goes straight to output
//  a result waits in the output register; the next beat is taken meanwhile
//  and only a finished sum stalls if the previous one is still held
// ----------------------------------------------------------------------------
module rectangle_sum_point_update import rspu_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration
  input  logic                    cfg_we_i,
  input  logic [CW-1:0]           cfg_grid_extent_i,
  // input beats
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    opcode_i,
  input  logic [CW-1:0]           x_first_i,
  input  logic [CW-1:0]           y_first_i,
  input  logic [CW-1:0]           x_last_i,
  input  logic [CW-1:0]           y_last_i,
  input  logic signed [VAL_W-1:0] value_i,
  // result beats
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [SUM_W-1:0] rect_sum_o
);

  cmd_t cmd;
  sts_t sts;

  // sequencer: clearing pass, row/column walk of the tree, hand-off
  rspu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // clamping, walk indexes, accumulator, cell memory, output register
  rspu_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_grid_extent_i (cfg_grid_extent_i),
    .opcode_i          (opcode_i),
    .x_first_i         (x_first_i),
    .y_first_i         (y_first_i),
    .x_last_i          (x_last_i),
    .y_last_i          (y_last_i),
    .value_i           (value_i),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .rect_sum_o        (rect_sum_o),
    .cmd_i             (cmd),
    .sts_o             (sts)
  );

endmodule
